@@ rtl/batch_job_scheduler_defines.svh @@
// Assertion helpers for the batch scheduler
`ifndef BATCH_JOB_SCHEDULER_DEFINES_SVH
`define BATCH_JOB_SCHEDULER_DEFINES_SVH

// checked only while out of reset
`define BJS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BJS_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/bjs_pkg.sv @@
`default_nettype none
package bjs_pkg;
    localparam int MAX_JOBS_DEF  = 16;
    localparam int TIME_BITS_DEF = 16;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 23;
    localparam int IDX_W  = 6;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] POLICY_FIFO = 2'd0;
    localparam logic [MODE_W-1:0] POLICY_SJF  = 2'd1;
    localparam logic [MODE_W-1:0] POLICY_SRT  = 2'd2;

    typedef struct packed {
        logic [IN_W-1:0] arrival_time;
        logic [IN_W-1:0] burst_length;
        logic            last_job;
    } t_job;

    typedef struct packed {
        logic [IDX_W-1:0] job_index;
        logic [OUT_W-1:0] start_time;
        logic [OUT_W-1:0] end_time;
        logic [OUT_W-1:0] turnaround;
        logic             last_result;
    } t_result;

    typedef struct packed {
        logic load;      // store the incoming job
        logic restart;   // rewind the scan pointer, drop scan results
        logic step;      // read the next entry
        logic act;       // apply the scan decision, then rewind
        logic out_mode;  // entries read now are reported
        logic clear;     // end of batch
    } t_cmd;

    typedef struct packed {
        logic addr_end;  // pointer reached job count
        logic pend;      // a read is still in flight
        logic any;       // scan found a ready job or a later arrival
    } t_status;
endpackage
`default_nettype wire

@@ rtl/bjs_ram.sv @@
`default_nettype none
module bjs_ram #(
    parameter  int W  = 16,
    parameter  int D  = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [W-1:0]      i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [W-1:0]      o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/bjs_ctrl.sv @@
`default_nettype none
module bjs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_last,
    input  wire bjs_pkg::t_status i_status,
    output bjs_pkg::t_cmd         o_cmd,
    output logic                  o_busy
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_OUT, S_FLUSH} t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last) begin
                        o_cmd.restart = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!i_status.addr_end) begin
                    o_cmd.step = 1'b1;
                end else if (!i_status.pend) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.any) begin
                    o_cmd.act = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.restart = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.out_mode = 1'b1;
                if (!i_status.addr_end) begin
                    o_cmd.step = 1'b1;
                end else if (!i_status.pend) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.clear = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            o_busy  <= (n_state != S_IDLE);
        end
    end
endmodule
`default_nettype wire

@@ rtl/bjs_datapath.sv @@
`default_nettype none
module bjs_datapath #(
    parameter int MAX_JOBS  = bjs_pkg::MAX_JOBS_DEF,
    parameter int TIME_BITS = bjs_pkg::TIME_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [bjs_pkg::MODE_W-1:0] i_cfg_wdata,
    input  wire bjs_pkg::t_job              i_job,
    input  wire bjs_pkg::t_cmd              i_cmd,
    output bjs_pkg::t_status                o_status,
    output logic                            o_result_valid,
    output bjs_pkg::t_result                o_result
);
    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int AW = (TIME_BITS < bjs_pkg::IN_W) ? TIME_BITS : bjs_pkg::IN_W;
    localparam int TW = bjs_pkg::OUT_W;

    logic [bjs_pkg::MODE_W-1:0] r_mode;
    logic [CW-1:0]       r_count;
    logic [TW-1:0]       r_time;
    logic [MAX_JOBS-1:0] r_fin;
    logic [MAX_JOBS-1:0] r_started;
    logic [CW-1:0]       r_addr;
    logic                r_pv;
    logic [IW-1:0]       r_pidx;

    // scan results
    logic                r_fr;
    logic [AW-1:0]       r_bk;
    logic [IW-1:0]       r_bi;
    logic [AW-1:0]       r_barr;
    logic [AW-1:0]       r_bburst;
    logic [AW-1:0]       r_brem;
    logic                r_ff;
    logic [AW-1:0]       r_fw;

    logic [AW-1:0] arr_q, bur_q, rem_q;
    logic [TW-1:0] st_q, en_q;

    logic is_sjf, is_srt, is_fifo;
    logic can_load;
    logic [IW-1:0] load_idx;
    logic [TW-1:0] arr_ext, fw_ext;
    logic [AW-1:0] key_q, keyv;
    logic rdy, take, fut;

    logic [TW-1:0] ts, tn, gap;
    logic [AW-1:0] run, remn;
    logic fin_now, fire;
    logic st_we, en_we, rem_we;
    logic [IW-1:0] rem_waddr;
    logic [AW-1:0] rem_wdata;

    assign is_sjf  = (r_mode == bjs_pkg::POLICY_SJF);
    assign is_srt  = (r_mode == bjs_pkg::POLICY_SRT);
    assign is_fifo = !is_sjf && !is_srt;

    assign can_load = i_cmd.load && (r_count < CW'(MAX_JOBS));
    assign load_idx = r_count[IW-1:0];

    // scan evaluation of the entry just read
    assign arr_ext = TW'(arr_q);
    assign key_q   = is_srt ? rem_q : bur_q;
    assign keyv    = is_fifo ? '0 : key_q;
    assign rdy     = !r_fin[r_pidx] && (is_fifo || arr_ext <= r_time);
    assign take    = r_pv && !i_cmd.out_mode && rdy && (!r_fr || keyv < r_bk);
    assign fut     = r_pv && !i_cmd.out_mode && !r_fin[r_pidx] && arr_ext > r_time
                     && (!r_ff || arr_q < r_fw);

    // decision; FIFO waits for its job, SRT stops at the next arrival
    assign fw_ext  = TW'(r_fw);
    assign ts      = (is_fifo && TW'(r_barr) > r_time) ? TW'(r_barr) : r_time;
    assign gap     = fw_ext - r_time;
    assign run     = (r_ff && gap < TW'(r_brem)) ? gap[AW-1:0] : r_brem;
    assign tn      = ts + TW'(is_srt ? run : r_bburst);
    assign remn    = r_brem - run;
    assign fin_now = !is_srt || (remn == '0);
    assign fire    = i_cmd.act && r_fr;

    assign st_we     = fire && (!is_srt || !r_started[r_bi]);
    assign en_we     = fire && fin_now;
    assign rem_we    = can_load || (fire && is_srt);
    assign rem_waddr = can_load ? load_idx : r_bi;
    assign rem_wdata = can_load ? i_job.burst_length[AW-1:0] : remn;

    bjs_ram #(.W(AW), .D(MAX_JOBS)) u_arr (
        .i_clk(i_clk), .i_we(can_load), .i_waddr(load_idx),
        .i_wdata(i_job.arrival_time[AW-1:0]), .i_raddr(r_addr[IW-1:0]), .o_rdata(arr_q)
    );
    bjs_ram #(.W(AW), .D(MAX_JOBS)) u_bur (
        .i_clk(i_clk), .i_we(can_load), .i_waddr(load_idx),
        .i_wdata(i_job.burst_length[AW-1:0]), .i_raddr(r_addr[IW-1:0]), .o_rdata(bur_q)
    );
    bjs_ram #(.W(AW), .D(MAX_JOBS)) u_rem (
        .i_clk(i_clk), .i_we(rem_we), .i_waddr(rem_waddr),
        .i_wdata(rem_wdata), .i_raddr(r_addr[IW-1:0]), .o_rdata(rem_q)
    );
    bjs_ram #(.W(TW), .D(MAX_JOBS)) u_st (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(r_bi),
        .i_wdata(ts), .i_raddr(r_addr[IW-1:0]), .o_rdata(st_q)
    );
    bjs_ram #(.W(TW), .D(MAX_JOBS)) u_en (
        .i_clk(i_clk), .i_we(en_we), .i_waddr(r_bi),
        .i_wdata(tn), .i_raddr(r_addr[IW-1:0]), .o_rdata(en_q)
    );

    assign o_status.addr_end = (r_addr == r_count);
    assign o_status.pend     = r_pv;
    assign o_status.any      = r_fr || r_ff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= bjs_pkg::POLICY_FIFO;
            r_count        <= '0;
            r_time         <= '0;
            r_fin          <= '0;
            r_started      <= '0;
            r_addr         <= '0;
            r_pv           <= 1'b0;
            r_fr           <= 1'b0;
            r_ff           <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (can_load) begin
                r_count             <= r_count + CW'(1);
                r_fin[load_idx]     <= 1'b0;
                r_started[load_idx] <= 1'b0;
            end
            // step is never raised together with act or restart
            r_pv <= i_cmd.step;
            if (i_cmd.step) begin
                r_addr <= r_addr + CW'(1);
            end
            if (take) begin
                r_fr <= 1'b1;
            end
            if (fut) begin
                r_ff <= 1'b1;
            end
            if (i_cmd.act) begin
                r_time <= r_fr ? tn : fw_ext;
                if (r_fr) begin
                    r_started[r_bi] <= 1'b1;
                    if (fin_now) begin
                        r_fin[r_bi] <= 1'b1;
                    end
                end
            end
            if (i_cmd.act || i_cmd.restart) begin
                r_addr <= '0;
                r_fr   <= 1'b0;
                r_ff   <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_count   <= '0;
                r_time    <= '0;
                r_fin     <= '0;
                r_started <= '0;
            end
            o_result_valid <= r_pv && i_cmd.out_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_pidx <= r_addr[IW-1:0];
        end
        if (take) begin
            r_bk     <= keyv;
            r_bi     <= r_pidx;
            r_barr   <= arr_q;
            r_bburst <= bur_q;
            r_brem   <= rem_q;
        end
        if (fut) begin
            r_fw <= arr_q;
        end
        if (r_pv && i_cmd.out_mode) begin
            o_result.job_index   <= bjs_pkg::IDX_W'(r_pidx);
            o_result.start_time  <= st_q;
            o_result.end_time    <= en_q;
            o_result.turnaround  <= (en_q > arr_ext) ? en_q - arr_ext : '0;
            o_result.last_result <= (CW'(r_pidx) + CW'(1) == r_count);
        end
    end
endmodule
`default_nettype wire

@@ rtl/batch_job_scheduler.sv @@
// channel   | ports                                  | handshake
// ----------+----------------------------------------+-------------------------------
// job in    | start, i_job                           | taken when start && !busy
// result    | o_result_valid, o_result               | one-cycle strobe, no back-pressure
// config    | i_cfg_we, i_cfg_wdata                  | written when i_cfg_we
//
// Jobs are loaded one per cycle while idle. After the last job each scheduling
// event is one scan of the N stored jobs through the job RAMs. FIFO needs N
// events plus a final empty scan; SJF and SRT at most 2N + 1, one per completion
// and one per distinct arrival that ends an idle gap or a preemption. Results then
// follow at one per cycle, and busy drops after the flush state that follows them.
// Reset is synchronous; results cannot be stalled.
`default_nettype none
`include "batch_job_scheduler_defines.svh"
module batch_job_scheduler #(
    parameter int MAX_JOBS  = bjs_pkg::MAX_JOBS_DEF,
    parameter int TIME_BITS = bjs_pkg::TIME_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    input  wire bjs_pkg::t_job              i_job,
    output logic                            busy,
    input  wire logic                       i_cfg_we,
    input  wire logic [bjs_pkg::MODE_W-1:0] i_cfg_wdata,
    output logic                            o_result_valid,
    output bjs_pkg::t_result                o_result
);
    bjs_pkg::t_cmd    cmd;
    bjs_pkg::t_status status;

    bjs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_last(i_job.last_job),
        .i_status(status), .o_cmd(cmd), .o_busy(busy)
    );

    bjs_datapath #(.MAX_JOBS(MAX_JOBS), .TIME_BITS(TIME_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_job(i_job), .i_cmd(cmd), .o_status(status),
        .o_result_valid(o_result_valid), .o_result(o_result)
    );

    `BJS_ASSERT(a_res_busy, o_result_valid |-> busy, "result outside a batch")
    `BJS_ASSERT(a_last_busy, (start && !busy && i_job.last_job) |=> busy, "batch not started")
    `BJS_ASSERT_ANY(a_rst_idle, !i_rst_n |=> (!busy && !o_result_valid), "not idle after reset")
endmodule
`default_nettype wire
